// ===== rtl/scudm_pkg.sv =====
// Shared types, constants and arithmetic helpers for the speaker channel mixer.
package scudm_pkg;

    localparam int MAX_CHANNELS = 6;
    localparam int SAMPLE_BITS  = 16;
    localparam int TDATA_W      = MAX_CHANNELS * SAMPLE_BITS;
    localparam int PAIR_W       = SAMPLE_BITS + 1;
    localparam int SUM_W        = SAMPLE_BITS + 4;
    localparam int RSQ_FRAC     = 15;
    localparam int PROD_W       = PAIR_W + RSQ_FRAC + 1;
    localparam int CNT_W        = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 3;

    // sqrt(0.5) in Q0.15
    localparam logic [RSQ_FRAC-1:0] RSQ_COEF = RSQ_FRAC'(23170);

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_CH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DST_CH  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPK_MOD = CFG_IDX_W'(2);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample [MAX_CHANNELS-1:0]    t_frame;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic signed [PAIR_W-1:0]      t_pair;

    typedef struct packed {
        logic [CNT_W-1:0] src_channels;
        logic [CNT_W-1:0] dst_channels;
        logic             speaker_mode;
    } t_cfg;

    typedef enum logic [3:0] {
        RULE_COPY,
        RULE_1_2,
        RULE_1_4,
        RULE_1_6,
        RULE_2_1,
        RULE_2_UP,
        RULE_4_1,
        RULE_4_2,
        RULE_4_6,
        RULE_6_1,
        RULE_6_2,
        RULE_6_4
    } t_rule;

    localparam t_sum SAT_MAX = t_sum'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam t_sum SAT_MIN = -SAT_MAX - t_sum'(1);

    function automatic logic [CNT_W-1:0] count_of(input logic [CNT_W-1:0] c);
        if (c == '0) begin
            return CNT_W'(1);
        end else if (c > CNT_W'(MAX_CHANNELS)) begin
            return CNT_W'(MAX_CHANNELS);
        end
        return c;
    endfunction

    function automatic t_sum ext(input t_sample s);
        return t_sum'(s);
    endfunction

    function automatic t_sample sat_sample(input t_sum v);
        if (v > SAT_MAX) begin
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (v < SAT_MIN) begin
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic is_clip(input t_sum v);
        return (v > SAT_MAX) || (v < SAT_MIN);
    endfunction

    function automatic t_rule rule_of(input logic [CNT_W-1:0] src,
                                      input logic [CNT_W-1:0] dst,
                                      input logic             spk);
        if (src == dst || !spk) begin
            return RULE_COPY;
        end
        case ({src, dst})
            6'o12:   return RULE_1_2;
            6'o14:   return RULE_1_4;
            6'o16:   return RULE_1_6;
            6'o21:   return RULE_2_1;
            6'o24:   return RULE_2_UP;
            6'o26:   return RULE_2_UP;
            6'o41:   return RULE_4_1;
            6'o42:   return RULE_4_2;
            6'o46:   return RULE_4_6;
            6'o61:   return RULE_6_1;
            6'o62:   return RULE_6_2;
            6'o64:   return RULE_6_4;
            default: return RULE_COPY;
        endcase
    endfunction

endpackage

// ===== rtl/speaker_channel_up_down_mixer_core.sv =====
// Top level: input register, mix matrix, output register, config registers.
//
//  port group   dir  tdata (low bit up)                 tuser    tlast
//  s_axis       in   in_left in_right in_ch2..in_ch5    -        frame_is_last
//  m_axis       out  out_ch0..out_ch5                   clipped  last_out
//  i_cfg_*      in   0 source, 1 target, 2 speaker_mode (write only)
//
// Beat path: input reg, output reg; one frame per cycle unless stalled.
// Input register and output register each hold one beat; while an output
// beat waits the input takes one more beat, then tready drops.
// Mix logic holds two 17x16 multiplies.
// Reset clears valids and loads source 2, target 2, speaker mode on.
module speaker_channel_up_down_mixer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [scudm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [scudm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [scudm_pkg::TDATA_W-1:0]     s_axis_tdata,  // in_left,in_right,in_ch2..in_ch5
    input  logic                              s_axis_tlast,  // frame_is_last
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [scudm_pkg::TDATA_W-1:0]     m_axis_tdata,  // out_ch0..out_ch5
    output logic                              m_axis_tuser,  // clipped
    output logic                              m_axis_tlast   // last_out
);

    scudm_pkg::t_cfg   w_cfg;
    scudm_pkg::t_frame w_mix_y;
    logic              w_mix_clip;
    logic              w_out_ready;

    logic              r_in_valid;
    scudm_pkg::t_frame r_in_frame;
    logic              r_in_last;
    logic              r_out_valid;
    scudm_pkg::t_frame r_out_frame;
    logic              r_out_clip;
    logic              r_out_last;

    scudm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    scudm_mix u_mix (
        .i_x    (r_in_frame),
        .i_cfg  (w_cfg),
        .o_y    (w_mix_y),
        .o_clip (w_mix_clip)
    );

    assign w_out_ready   = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_frame <= s_axis_tdata;
            r_in_last  <= s_axis_tlast;
        end
        if (w_out_ready && r_in_valid) begin
            r_out_frame <= w_mix_y;
            r_out_clip  <= w_mix_clip;
            r_out_last  <= r_in_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_frame;
    assign m_axis_tuser  = r_out_clip;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/scudm_cfg.sv =====
// Configuration register file: channel counts and mix mode.
module scudm_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [scudm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [scudm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output scudm_pkg::t_cfg                     o_cfg
);

    scudm_pkg::t_cfg r_cfg;
    scudm_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                scudm_pkg::CFG_SRC_CH:  n_cfg.src_channels = i_cfg_data;
                scudm_pkg::CFG_DST_CH:  n_cfg.dst_channels = i_cfg_data;
                scudm_pkg::CFG_SPK_MOD: n_cfg.speaker_mode = i_cfg_data[0];
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_channels <= scudm_pkg::CNT_W'(2);
            r_cfg.dst_channels <= scudm_pkg::CNT_W'(2);
            r_cfg.speaker_mode <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/scudm_mix.sv =====
// Combinational up/down-mix matrix with saturation.
module scudm_mix (
    input  scudm_pkg::t_frame i_x,
    input  scudm_pkg::t_cfg   i_cfg,
    output scudm_pkg::t_frame o_y,
    output logic              o_clip
);

    logic [scudm_pkg::CNT_W-1:0]    src;
    logic [scudm_pkg::CNT_W-1:0]    dst;
    scudm_pkg::t_rule               rule;
    scudm_pkg::t_sum                xs [scudm_pkg::MAX_CHANNELS];
    scudm_pkg::t_sum                ys [scudm_pkg::MAX_CHANNELS];
    scudm_pkg::t_pair               pa;
    scudm_pkg::t_pair               pb;
    logic signed [scudm_pkg::PROD_W-1:0] pm_a;
    logic signed [scudm_pkg::PROD_W-1:0] pm_b;
    scudm_pkg::t_sum                ra;
    scudm_pkg::t_sum                rb;

    always_comb begin
        src  = scudm_pkg::count_of(i_cfg.src_channels);
        dst  = scudm_pkg::count_of(i_cfg.dst_channels);
        rule = scudm_pkg::rule_of(src, dst, i_cfg.speaker_mode);
        for (int i = 0; i < scudm_pkg::MAX_CHANNELS; i++) begin
            xs[i] = (scudm_pkg::CNT_W'(i) < src) ? scudm_pkg::ext(i_x[i]) : '0;
        end
    end

    // sqrt(0.5) products, floor on the dropped bits
    always_comb begin
        case (rule)
            scudm_pkg::RULE_6_1: pa = scudm_pkg::t_pair'(xs[0] + xs[1]);
            scudm_pkg::RULE_6_2: pa = scudm_pkg::t_pair'(xs[2] + xs[4]);
            default:             pa = scudm_pkg::t_pair'(xs[2]);
        endcase
        pb   = scudm_pkg::t_pair'(xs[2] + xs[5]);
        pm_a = scudm_pkg::PROD_W'(pa)
             * scudm_pkg::PROD_W'($signed({1'b0, scudm_pkg::RSQ_COEF}));
        pm_b = scudm_pkg::PROD_W'(pb)
             * scudm_pkg::PROD_W'($signed({1'b0, scudm_pkg::RSQ_COEF}));
        ra   = scudm_pkg::SUM_W'($signed(pm_a[scudm_pkg::PROD_W-1:scudm_pkg::RSQ_FRAC]));
        rb   = scudm_pkg::SUM_W'($signed(pm_b[scudm_pkg::PROD_W-1:scudm_pkg::RSQ_FRAC]));
    end

    always_comb begin
        for (int i = 0; i < scudm_pkg::MAX_CHANNELS; i++) begin
            ys[i] = '0;
        end
        case (rule)
            scudm_pkg::RULE_1_2, scudm_pkg::RULE_1_4: begin
                ys[0] = xs[0];
                ys[1] = xs[0];
            end
            scudm_pkg::RULE_1_6: ys[2] = xs[0];
            scudm_pkg::RULE_2_1: ys[0] = (xs[0] + xs[1]) >>> 1;
            scudm_pkg::RULE_2_UP: begin
                ys[0] = xs[0];
                ys[1] = xs[1];
            end
            scudm_pkg::RULE_4_1: ys[0] = (xs[0] + xs[1] + xs[2] + xs[3]) >>> 2;
            scudm_pkg::RULE_4_2: begin
                ys[0] = (xs[0] + xs[2]) >>> 1;
                ys[1] = (xs[1] + xs[3]) >>> 1;
            end
            scudm_pkg::RULE_4_6: begin
                ys[0] = xs[0];
                ys[1] = xs[1];
                ys[4] = xs[2];
                ys[5] = xs[3];
            end
            scudm_pkg::RULE_6_1: ys[0] = ra + xs[2] + ((xs[4] + xs[5]) >>> 1);
            scudm_pkg::RULE_6_2: begin
                ys[0] = xs[0] + ra;
                ys[1] = xs[1] + rb;
            end
            scudm_pkg::RULE_6_4: begin
                ys[0] = xs[0] + ra;
                ys[1] = xs[1] + ra;
                ys[2] = xs[4];
                ys[3] = xs[5];
            end
            default: begin
                for (int i = 0; i < scudm_pkg::MAX_CHANNELS; i++) begin
                    ys[i] = (scudm_pkg::CNT_W'(i) < dst) ? xs[i] : '0;
                end
            end
        endcase
    end

    always_comb begin
        o_clip = 1'b0;
        for (int i = 0; i < scudm_pkg::MAX_CHANNELS; i++) begin
            if (scudm_pkg::CNT_W'(i) < dst) begin
                o_y[i] = scudm_pkg::sat_sample(ys[i]);
                o_clip = o_clip | scudm_pkg::is_clip(ys[i]);
            end else begin
                o_y[i] = '0;
            end
        end
    end

endmodule

// ===== rtl/scudm_chk.sv =====
// Port-level checker for the mixer core, bound to the top level.
module scudm_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [scudm_pkg::TDATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_full_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a stalled output");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("accepted beat not shown two cycles later");

endmodule

bind speaker_channel_up_down_mixer_core scudm_chk u_scudm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
